[hw/rtl/partition_fit_allocator_assert.svh]
// assertion macros used by pfa_engine of the partition fit allocator rtl
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef PARTITION_FIT_ALLOCATOR_ASSERT_SVH
`define PARTITION_FIT_ALLOCATOR_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define PFA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfa assertion failed");

// next-cycle implication, disabled while in reset
`define PFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfa assertion failed");

`endif

[hw/rtl/pfa_pkg.sv]
// shared types and codes for the partition fit allocator
// no dependencies; used by pfa_engine and partition_fit_allocator
`default_nettype none

package pfa_pkg;

    localparam int SIZE_W = 16;
    localparam int HOLE_IW = 4;

    // operation codes of an input item
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_ALLOC = 1'b1;

    // placement policy codes
    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    typedef enum logic [1:0] {
        ST_LOADED = 2'd0,
        ST_ALLOC  = 2'd1,
        ST_NOFIT  = 2'd2
    } pfa_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_CMPL,
        S_DONE
    } pfa_state_t;

    typedef struct packed {
        logic               func;
        logic [HOLE_IW-1:0] hole_index;
        logic [SIZE_W-1:0]  size_value;
    } pfa_cmd_t;

    typedef struct packed {
        pfa_status_t        status;
        logic [HOLE_IW-1:0] chosen_hole;
        logic [SIZE_W-1:0]  chosen_size;
        logic [SIZE_W-1:0]  leftover;
    } pfa_result_t;

endpackage

`default_nettype wire

[hw/rtl/partition_fit_allocator.sv]
// load: accepted in S_IDLE, then its result is offered in S_DONE; allocate: S_IDLE,
// then S_SCAN, which reads one hole size per cycle from the size memory, S_CMPL
// and S_DONE. one item in flight; the next item is accepted the cycle after its
// result is handed to the output register. rst_n clears fit_mode to first fit and
// all present/taken bits; hole sizes are not cleared and need no clearing pass
`default_nettype none

module partition_fit_allocator
    import pfa_pkg::*;
#(
    parameter int NUM_HOLES = 16
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic         func,
    input  wire logic [3:0]   hole_index,
    input  wire logic [15:0]  size_value,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [1:0]        status,
    output logic [3:0]        chosen_hole,
    output logic [15:0]       chosen_size,
    output logic [15:0]       leftover
);

    logic [1:0]  fit_mode_reg;
    logic        out_valid_reg;
    pfa_result_t out_data_reg;

    pfa_cmd_t    cmd;
    pfa_result_t res;
    logic        res_valid;
    logic        res_ready;
    logic        reg_sel;

    // register 0 sits at byte address 0; paddr[2] selects beyond it
    assign reg_sel = !paddr[2];
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {30'b0, fit_mode_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg <= FIT_FIRST;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            fit_mode_reg <= pwdata[1:0];
        end
    end

    assign cmd.func       = func;
    assign cmd.hole_index = hole_index;
    assign cmd.size_value = size_value;

    pfa_engine #(
        .NUM_HOLES (NUM_HOLES)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (in_valid),
        .cmd_ready (in_ready),
        .cmd       (cmd),
        .fit_mode  (fit_mode_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register takes a result from the engine when it is empty or being drained
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_data_reg.status;
    assign chosen_hole = out_data_reg.chosen_hole;
    assign chosen_size = out_data_reg.chosen_size;
    assign leftover    = out_data_reg.leftover;

endmodule

`default_nettype wire

[hw/rtl/pfa_engine.sv]
// hole table engine: size memory, present/taken bitmaps and the scan sequencer
// depends on pfa_pkg and partition_fit_allocator_assert.svh
`default_nettype none
`include "partition_fit_allocator_assert.svh"

module pfa_engine
    import pfa_pkg::*;
#(
    parameter int NUM_HOLES = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cmd_valid,
    output logic             cmd_ready,
    input  wire pfa_cmd_t    cmd,
    input  wire logic [1:0]  fit_mode,
    output logic             res_valid,
    input  wire logic        res_ready,
    output pfa_result_t      res
);

    localparam int IW = $clog2(NUM_HOLES);

    pfa_state_t state_reg, state_next;

    logic [SIZE_W-1:0]     size_mem [NUM_HOLES];
    logic [SIZE_W-1:0]     rd_data_reg;
    logic [IW-1:0]         scan_cnt_reg;
    logic                  cmp_vld_reg;
    logic [IW-1:0]         cmp_idx_reg;
    logic [SIZE_W-1:0]     req_size_reg;
    logic                  is_alloc_reg;
    logic                  found_reg;
    logic [IW-1:0]         best_idx_reg;
    logic [SIZE_W-1:0]     best_size_reg;
    logic [NUM_HOLES-1:0]  present_reg;
    logic [NUM_HOLES-1:0]  taken_reg;

    logic          cmd_fire;
    logic          res_fire;
    logic          load_in_range;
    logic          mem_we;
    logic [IW-1:0] wr_addr;
    logic          scan_last;
    logic          eligible;
    logic          policy_better;
    logic          cmp_take;

    assign cmd_fire      = cmd_valid && cmd_ready;
    assign res_fire      = res_valid && res_ready;
    assign wr_addr       = IW'(cmd.hole_index);
    assign load_in_range = 32'(cmd.hole_index) < NUM_HOLES;
    assign scan_last     = scan_cnt_reg == IW'(NUM_HOLES - 1);

    // comparison stage works on the entry read in the previous cycle
    assign eligible = present_reg[cmp_idx_reg] && !taken_reg[cmp_idx_reg]
                      && (rd_data_reg >= req_size_reg);

    always_comb
    begin
        case (fit_mode)
            FIT_BEST:  policy_better = rd_data_reg < best_size_reg;
            FIT_WORST: policy_better = rd_data_reg > best_size_reg;
            default:   policy_better = 1'b0;
        endcase
    end

    assign cmp_take = cmp_vld_reg && eligible && (!found_reg || policy_better);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = (cmd.func == FUNC_ALLOC) ? S_SCAN : S_DONE;
                end
            end
            S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = S_CMPL;
                end
            end
            S_CMPL:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd_ready = 1'b0;
        res_valid = 1'b0;
        mem_we    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                mem_we    = cmd_valid && (cmd.func == FUNC_LOAD) && load_in_range;
            end
            S_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        res = '0;
        if (!is_alloc_reg)
        begin
            res.status = ST_LOADED;
        end
        else if (found_reg)
        begin
            res.status      = ST_ALLOC;
            res.chosen_hole = HOLE_IW'(best_idx_reg);
            res.chosen_size = best_size_reg;
            res.leftover    = best_size_reg - req_size_reg;
        end
        else
        begin
            res.status = ST_NOFIT;
        end
    end

    // size memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            size_mem[wr_addr] <= cmd.size_value;
        end
        rd_data_reg <= size_mem[scan_cnt_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            scan_cnt_reg <= '0;
            cmp_vld_reg  <= 1'b0;
            is_alloc_reg <= 1'b0;
            found_reg    <= 1'b0;
            present_reg  <= '0;
            taken_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cmp_vld_reg <= (state_reg == S_SCAN);
            if (cmd_fire)
            begin
                is_alloc_reg <= (cmd.func == FUNC_ALLOC);
                found_reg    <= 1'b0;
                scan_cnt_reg <= '0;
            end
            else
            begin
                if (state_reg == S_SCAN)
                begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                end
                if (cmp_take)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (mem_we)
            begin
                present_reg[wr_addr] <= 1'b1;
                taken_reg[wr_addr]   <= 1'b0;
            end
            if (res_fire && is_alloc_reg && found_reg)
            begin
                taken_reg[best_idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= scan_cnt_reg;
        if (cmd_fire)
        begin
            req_size_reg <= cmd.size_value;
        end
        if (cmp_take)
        begin
            best_idx_reg  <= cmp_idx_reg;
            best_size_reg <= rd_data_reg;
        end
    end

    `PFA_ASSERT_NOW(a_ready_excl_result, clk, rst_n, cmd_ready, !res_valid)
    `PFA_ASSERT_NOW(a_alloc_hole_free, clk, rst_n,
        res_valid && is_alloc_reg && found_reg,
        present_reg[best_idx_reg] && !taken_reg[best_idx_reg])
    `PFA_ASSERT_NOW(a_alloc_fits, clk, rst_n,
        res_valid && is_alloc_reg && found_reg, best_size_reg >= req_size_reg)
    `PFA_ASSERT_NEXT(a_result_frees, clk, rst_n, res_fire, state_reg == S_IDLE)
    `PFA_ASSERT_NEXT(a_taken_marked, clk, rst_n,
        res_fire && is_alloc_reg && found_reg, taken_reg[$past(best_idx_reg)])

endmodule

`default_nettype wire
